FILE: hw/rtl/arpc_pkg.sv
// Shared types, codes and constants of the ARP cache with entry aging.
// No dependencies; used by the compare unit and the top level.
package arpc_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int TIME_W   = 32;
    localparam int TMO_W    = 16;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;
    localparam int ENTRY_W  = IP_W + MAC_W + TIME_W;

    // Packed entry word, lowest bits first: expiry, mac, ip.
    localparam int EXP_LSB  = 0;
    localparam int MAC_LSB  = TIME_W;
    localparam int IP_LSB   = TIME_W + MAC_W;

    localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(600);

    // Input actions.
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NEW     = 3'd2;
    localparam logic [STAT_W-1:0] ST_UPDATED = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
    localparam logic [STAT_W-1:0] ST_TICK    = 3'd5;

    // Configuration register indexes.
    localparam logic REG_TIMEOUT   = 1'b0;
    localparam logic REG_EXPIRY_EN = 1'b1;

    // Verdict of the compare unit on one table entry.
    typedef struct packed {
        logic hit;      // valid and address matches
        logic expired;  // expiry checks on and expiry not later than now
        logic free;     // slot may take a new entry
    } t_cmp_res;

endpackage

FILE: hw/rtl/arp_cache_with_aging_unit.sv
// ARP cache with entry aging: top level, sequencer, valid bits and clock.
// Lookup and insert scan the whole table, reading one table entry per cycle through
// the compare unit, before the result is raised; ticks and unknown actions go straight
// to the finishing state. The next transaction can be accepted in the cycle the result
// is raised; a held result stalls the finishing state until the output drains.
// Reset (synchronous, active low) clears all valid bits at once, zeroes the
// seconds counter and loads timeout 600 and expiry enabled; no clearing pass.
// Depends on arpc_pkg, arpc_ram and arpc_cmp.
module arp_cache_with_aging_unit
    import arpc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Configuration write channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [TMO_W-1:0]  i_cfg_data,

    // Request stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [79:0]       s_axis_tdata,   // [31:0] ip_addr, [79:32] mac_in
    input  logic [7:0]        s_axis_tuser,   // [1:0] action, [7:2] zero

    // Result stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // [47:0] mac_out
    output logic [7:0]        m_axis_tuser    // [2:0] status, [3] found, [7:4] zero
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]          r_state, n_state;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [TMO_W-1:0]    r_timeout;
    logic                r_exp_en;

    // Latched request.
    logic [ACT_W-1:0]    r_action, n_action;
    logic [IP_W-1:0]     r_ip, n_ip;
    logic [MAC_W-1:0]    r_mac, n_mac;

    // Scan pointer and read pipeline.
    logic [IW-1:0]       r_addr, n_addr;
    logic                r_issuing, n_issuing;
    logic                r_rvld, n_rvld;
    logic [IW-1:0]       r_ridx, n_ridx;

    // Scan findings: first matching entry and first free slot.
    logic                r_match, n_match;
    logic                r_match_exp, n_match_exp;
    logic [IW-1:0]       r_match_idx, n_match_idx;
    logic [MAC_W-1:0]    r_match_mac, n_match_mac;
    logic                r_free, n_free;
    logic [IW-1:0]       r_free_idx, n_free_idx;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic                r_out_found, n_out_found;
    logic [MAC_W-1:0]    r_out_mac, n_out_mac;

    // ------------------------------------------------------------------
    // Table memory and shared compare unit
    // ------------------------------------------------------------------
    logic                ram_wr_en;
    logic [IW-1:0]       ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic [ENTRY_W-1:0]  ram_rd_data;
    t_cmp_res            cmp_res;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (r_issuing),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_rd_data)
    );

    arpc_cmp u_cmp (
        .i_valid        (r_valid[r_ridx]),
        .i_entry_ip     (ram_rd_data[IP_LSB +: IP_W]),
        .i_entry_expiry (ram_rd_data[EXP_LSB +: TIME_W]),
        .i_key          (r_ip),
        .i_now          (r_now),
        .i_expiry_en    (r_exp_en),
        .o_res          (cmp_res)
    );

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_fire;
    logic commit;
    logic live_match;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    // Finish the transaction only when the output register is free or draining.
    assign commit        = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);
    assign live_match    = r_match && !r_match_exp;

    // New expiry: now plus timeout, saturating at the top of the clock.
    logic [TIME_W:0]     exp_sum;
    logic [TIME_W-1:0]   exp_new;

    assign exp_sum = {1'b0, r_now} + (TIME_W + 1)'(r_timeout);
    assign exp_new = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

    assign ram_wr_data = {r_ip, r_mac, exp_new};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_now        = r_now;
        n_action     = r_action;
        n_ip         = r_ip;
        n_mac        = r_mac;
        n_addr       = r_addr;
        n_issuing    = r_issuing;
        n_rvld       = 1'b0;
        n_ridx       = r_addr;
        n_match      = r_match;
        n_match_exp  = r_match_exp;
        n_match_idx  = r_match_idx;
        n_match_mac  = r_match_mac;
        n_free       = r_free;
        n_free_idx   = r_free_idx;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_mac    = r_out_mac;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_match_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_action  = s_axis_tuser[ACT_W-1:0];
                    n_ip      = s_axis_tdata[IP_W-1:0];
                    n_mac     = s_axis_tdata[IP_W +: MAC_W];
                    n_addr    = '0;
                    n_match   = 1'b0;
                    n_free    = 1'b0;
                    if ((s_axis_tuser[ACT_W-1:0] == ACT_LOOKUP) ||
                        (s_axis_tuser[ACT_W-1:0] == ACT_INSERT)) begin
                        n_issuing = 1'b1;
                        n_state   = S_SCAN;
                    end else begin
                        n_state   = S_FIN;
                    end
                end
            end

            S_SCAN: begin
                // Issue one read a cycle, judge the entry that returns.
                n_rvld = r_issuing;
                if (r_issuing) begin
                    if (r_addr == LAST_IDX) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_addr = r_addr + IW'(1);
                    end
                end
                if (r_rvld) begin
                    if (!r_match && cmp_res.hit) begin
                        n_match     = 1'b1;
                        n_match_exp = cmp_res.expired;
                        n_match_idx = r_ridx;
                        n_match_mac = ram_rd_data[MAC_LSB +: MAC_W];
                    end
                    if (!r_free && cmp_res.free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_ridx;
                    end
                    if (r_ridx == LAST_IDX) begin
                        n_state = S_FIN;
                    end
                end
            end

            S_FIN: begin
                if (commit) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_MISS;
                    n_out_found  = 1'b0;
                    n_out_mac    = '0;
                    n_state      = S_IDLE;
                    // Drop an expired match before any new fill.
                    if (r_match && r_match_exp &&
                        ((r_action == ACT_LOOKUP) || (r_action == ACT_INSERT))) begin
                        n_valid[r_match_idx] = 1'b0;
                    end
                    priority if (r_action == ACT_LOOKUP) begin
                        if (live_match) begin
                            n_out_status = ST_HIT;
                            n_out_found  = 1'b1;
                            n_out_mac    = r_match_mac;
                        end
                    end else if (r_action == ACT_INSERT) begin
                        if (live_match) begin
                            ram_wr_en    = 1'b1;
                            ram_wr_addr  = r_match_idx;
                            n_out_status = ST_UPDATED;
                        end else if (r_free) begin
                            ram_wr_en           = 1'b1;
                            ram_wr_addr         = r_free_idx;
                            n_valid[r_free_idx] = 1'b1;
                            n_out_status        = ST_NEW;
                        end else begin
                            n_out_status = ST_FULL;
                        end
                    end else if (r_action == ACT_TICK) begin
                        if (r_now != {TIME_W{1'b1}}) begin
                            n_now = r_now + TIME_W'(1);
                        end
                        n_out_status = ST_TICK;
                    end else begin
                        // Unknown action: report a miss, change nothing.
                        n_out_status = ST_MISS;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_now       <= '0;
            r_timeout   <= TIMEOUT_RST;
            r_exp_en    <= 1'b1;
            r_issuing   <= 1'b0;
            r_rvld      <= 1'b0;
            r_match     <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_now       <= n_now;
            r_issuing   <= n_issuing;
            r_rvld      <= n_rvld;
            r_match     <= n_match;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_TIMEOUT:   r_timeout <= i_cfg_data;
                    REG_EXPIRY_EN: r_exp_en  <= i_cfg_data[0];
                    default:       ;
                endcase
            end
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_ip         <= n_ip;
        r_mac        <= n_mac;
        r_addr       <= n_addr;
        r_ridx       <= n_ridx;
        r_match_exp  <= n_match_exp;
        r_match_idx  <= n_match_idx;
        r_match_mac  <= n_match_mac;
        r_free_idx   <= n_free_idx;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_mac    <= n_out_mac;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_mac;
    assign m_axis_tuser  = {4'b0000, r_out_found, r_out_status};

`ifndef SYNTHESIS
    // Read data returns only during the scan.
    a_rvld_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvld |-> (r_state == S_SCAN))
        else $error("table read returned outside the scan");

    // A new result appears only out of the finishing state.
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside the finishing state");

    // The seconds counter never runs backward.
    a_now_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_now >= $past(r_now)))
        else $error("seconds counter decreased");

    // A fill into a free slot leaves that slot valid.
    a_fill_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_action == ACT_INSERT) && !live_match && r_free)
            |=> r_valid[$past(r_free_idx)])
        else $error("filled slot not marked valid");
`endif

endmodule

FILE: hw/rtl/arpc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/arpc_cmp.sv
// Shared compare unit: judges one table entry against the key and the clock.
// Depends on arpc_pkg.
module arpc_cmp
    import arpc_pkg::*;
(
    input  logic              i_valid,
    input  logic [IP_W-1:0]   i_entry_ip,
    input  logic [TIME_W-1:0] i_entry_expiry,
    input  logic [IP_W-1:0]   i_key,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_expiry_en,
    output t_cmp_res          o_res
);

    logic expired;

    assign expired       = i_expiry_en && (i_entry_expiry <= i_now);
    assign o_res.hit     = i_valid && (i_entry_ip == i_key);
    assign o_res.expired = expired;
    assign o_res.free    = !i_valid || expired;

endmodule
